[rtl/public_id_urn_encoder_unit_macros.svh]
// Assertion macros used by the URN encoder back end.
`ifndef PUBLIC_ID_URN_ENCODER_UNIT_MACROS_SVH
`define PUBLIC_ID_URN_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define URNENC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urnenc: implication failed");

// next-cycle implication, ignored while reset is held
`define URNENC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urnenc: next-cycle implication failed");

`endif

[rtl/urnenc_pkg.sv]
// Types, character codes and helper functions for the URN encoder.
`timescale 1ns / 1ps
`default_nettype none

package urnenc_pkg;

    localparam int PREFIX_LEN = 13;
    localparam int IDX_W      = 4;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [IDX_W-1:0] IDX_PREFIX_LAST = IDX_W'(PREFIX_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_ESC_LAST    = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_ZERO        = IDX_W'(0);

    typedef enum logic [1:0] {
        PAIR_NONE,
        PAIR_COLON,
        PAIR_SLASH
    } pair_t;

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_CHAR,
        MAIN_ESC
    } main_t;

    // back-end sequencing, in emission order
    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_PLUS,
        PH_FLUSH,
        PH_MAIN,
        PH_FLUSH2,
        PH_END,
        PH_DONE
    } phase_t;

    // one command per input beat that produces any output characters
    typedef struct packed {
        logic       prefix;
        logic       plus;
        pair_t      flush;
        main_t      main_kind;
        logic [7:0] ch;
        pair_t      flush2;
        logic       fin;
    } cmd_t;

    function automatic logic [7:0] prefix_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h75; // u
            4'd1:    c = 8'h72; // r
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h3A; // :
            4'd4:    c = 8'h70; // p
            4'd5:    c = 8'h75; // u
            4'd6:    c = 8'h62; // b
            4'd7:    c = 8'h6C; // l
            4'd8:    c = 8'h69; // i
            4'd9:    c = 8'h63; // c
            4'd10:   c = 8'h69; // i
            4'd11:   c = 8'h64; // d
            4'd12:   c = 8'h3A; // :
            default: c = 8'h3A;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'h0, n};
        end else begin
            c = 8'h37 + {4'h0, n};
        end
        return c;
    endfunction

    // character idx of the three-character escape of c
    function automatic logic [7:0] esc_char(input logic [7:0] c, input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = CH_PCT;
            4'd1:    r = hex_digit(c[7:4]);
            default: r = hex_digit(c[3:0]);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pair_char(input pair_t p);
        return (p == PAIR_SLASH) ? CH_SLASH : CH_COLON;
    endfunction

    // first phase after p that this command actually uses
    function automatic phase_t next_phase(input phase_t p, input cmd_t c);
        phase_t n;
        n = PH_DONE;
        if (p < PH_END && c.fin)                   n = PH_END;
        if (p < PH_FLUSH2 && c.flush2 != PAIR_NONE) n = PH_FLUSH2;
        if (p < PH_MAIN && c.main_kind != MAIN_NONE) n = PH_MAIN;
        if (p < PH_FLUSH && c.flush != PAIR_NONE)   n = PH_FLUSH;
        if (p < PH_PLUS && c.plus)                  n = PH_PLUS;
        if (p < PH_PREFIX && c.prefix)              n = PH_PREFIX;
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/urnenc_front.sv]
// Front end: accepts characters, tracks whitespace and pair state, issues commands.
`timescale 1ns / 1ps
`default_nettype none

module urnenc_front (
    input  wire                logic       aclk,
    input  wire                logic       aresetn,
    input  wire                logic       s_tvalid,
    output                     logic       s_tready,
    input  wire                logic [7:0] s_tdata,  // [7:0] char_in
    input  wire                logic       s_tuser,  // has_char
    input  wire                logic       s_tlast,  // end_of_id
    input  wire                logic       cmd_ready,
    output                     logic       cmd_push,
    output urnenc_pkg::cmd_t               cmd
);
    import urnenc_pkg::*;

    logic  prefix_sent_reg, prefix_sent_next;
    logic  body_started_reg, body_started_next;
    logic  space_pending_reg, space_pending_next;
    pair_t pair_reg, pair_next;

    logic  accept;
    logic  is_ws;
    logic  needs_esc;
    pair_t pair_mid;

    assign s_tready = cmd_ready;
    assign accept   = s_tvalid && cmd_ready;
    assign is_ws    = (s_tdata == CH_SPACE) || (s_tdata >= CH_TAB && s_tdata <= CH_CR);

    always_comb begin
        unique case (s_tdata) inside
            CH_PCT, CH_SEMI, CH_APOS, CH_QUEST, CH_HASH, CH_PLUS: needs_esc = 1'b1;
            default:                                              needs_esc = 1'b0;
        endcase
    end

    always_comb begin
        cmd                = '0;
        cmd.flush          = PAIR_NONE;
        cmd.main_kind      = MAIN_NONE;
        cmd.flush2         = PAIR_NONE;
        cmd.ch             = s_tdata;
        prefix_sent_next   = prefix_sent_reg;
        body_started_next  = body_started_reg;
        space_pending_next = space_pending_reg;
        pair_mid           = pair_reg;

        if (s_tuser || s_tlast) begin
            cmd.prefix       = !prefix_sent_reg;
            prefix_sent_next = 1'b1;
        end

        if (s_tuser) begin
            if (is_ws) begin
                if (body_started_reg) begin
                    cmd.flush          = pair_reg;
                    pair_mid           = PAIR_NONE;
                    space_pending_next = 1'b1;
                end
            end else begin
                cmd.plus           = space_pending_reg;
                space_pending_next = 1'b0;
                body_started_next  = 1'b1;
                if (s_tdata == CH_COLON) begin
                    if (pair_reg == PAIR_COLON) begin
                        cmd.main_kind = MAIN_CHAR;
                        cmd.ch        = CH_SEMI;
                        pair_mid      = PAIR_NONE;
                    end else begin
                        cmd.flush = pair_reg;
                        pair_mid  = PAIR_COLON;
                    end
                end else if (s_tdata == CH_SLASH) begin
                    if (pair_reg == PAIR_SLASH) begin
                        cmd.main_kind = MAIN_CHAR;
                        cmd.ch        = CH_COLON;
                        pair_mid      = PAIR_NONE;
                    end else begin
                        cmd.flush = pair_reg;
                        pair_mid  = PAIR_SLASH;
                    end
                end else begin
                    cmd.flush     = pair_reg;
                    pair_mid      = PAIR_NONE;
                    cmd.main_kind = needs_esc ? MAIN_ESC : MAIN_CHAR;
                end
            end
        end

        pair_next = pair_mid;
        if (s_tlast) begin
            // end of string: flush what is left and return to the idle state
            cmd.flush2         = pair_mid;
            cmd.fin            = 1'b1;
            pair_next          = PAIR_NONE;
            prefix_sent_next   = 1'b0;
            body_started_next  = 1'b0;
            space_pending_next = 1'b0;
        end
    end

    assign cmd_push = accept && (cmd.prefix || cmd.plus || cmd.flush != PAIR_NONE ||
                                 cmd.main_kind != MAIN_NONE || cmd.flush2 != PAIR_NONE ||
                                 cmd.fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_sent_reg   <= 1'b0;
            body_started_reg  <= 1'b0;
            space_pending_reg <= 1'b0;
            pair_reg          <= PAIR_NONE;
        end else if (accept) begin
            prefix_sent_reg   <= prefix_sent_next;
            body_started_reg  <= body_started_next;
            space_pending_reg <= space_pending_next;
            pair_reg          <= pair_next;
        end
    end

endmodule

`default_nettype wire

[rtl/urnenc_cmd_fifo.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module urnenc_cmd_fifo (
    input  wire              logic aclk,
    input  wire              logic aresetn,
    input  wire              logic push,
    input  wire urnenc_pkg::cmd_t  wr_cmd,
    output                   logic not_full,
    input  wire              logic pop,
    output                   logic not_empty,
    output urnenc_pkg::cmd_t       rd_cmd
);
    import urnenc_pkg::*;

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_full  = count_reg != (CMDQ_AW + 1)'(CMDQ_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign rd_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (CMDQ_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (CMDQ_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/urnenc_back.sv]
// Back end: expands commands into characters, one-character hold-back, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "public_id_urn_encoder_unit_macros.svh"

module urnenc_back (
    input  wire              logic       aclk,
    input  wire              logic       aresetn,
    input  wire              logic       cmd_valid,
    input  wire urnenc_pkg::cmd_t        cmd,
    output                   logic       cmd_pop,
    output                   logic       m_tvalid,
    input  wire              logic       m_tready,
    output                   logic [7:0] m_tdata,  // [7:0] char_out
    output                   logic       m_tuser,  // end_of_urn
    output                   logic       m_tlast   // last_of_run
);
    import urnenc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_end_reg, out_end_next;

    phase_t           cur_phase, after_phase;
    logic [IDX_W-1:0] last_idx;
    logic             phase_last, cmd_last, is_end_step;
    logic [7:0]       emit_char;
    logic             push, slot_free, fire;

    always_comb begin
        cur_phase   = (phase_reg == PH_START) ? next_phase(PH_START, cmd) : phase_reg;
        after_phase = next_phase(cur_phase, cmd);
        unique case (cur_phase)
            PH_PREFIX:            last_idx = IDX_PREFIX_LAST;
            PH_FLUSH, PH_FLUSH2:  last_idx = IDX_ESC_LAST;
            PH_MAIN:              last_idx = (cmd.main_kind == MAIN_ESC) ? IDX_ESC_LAST : IDX_ZERO;
            default:              last_idx = IDX_ZERO;
        endcase
        unique case (cur_phase)
            PH_PREFIX: emit_char = prefix_char(idx_reg);
            PH_PLUS:   emit_char = CH_PLUS;
            PH_FLUSH:  emit_char = esc_char(pair_char(cmd.flush), idx_reg);
            PH_FLUSH2: emit_char = esc_char(pair_char(cmd.flush2), idx_reg);
            PH_MAIN:   emit_char = (cmd.main_kind == MAIN_ESC) ? esc_char(cmd.ch, idx_reg)
                                                               : cmd.ch;
            default:   emit_char = cmd.ch;
        endcase
        phase_last  = idx_reg == last_idx;
        cmd_last    = phase_last && (after_phase == PH_DONE);
        is_end_step = cur_phase == PH_END;
        // a character leaves only once the next one displaces it, or at the end
        push        = is_end_step || held_valid_reg;
        slot_free   = !out_valid_reg || m_tready;
        fire        = cmd_valid && (!push || slot_free);
    end

    assign cmd_pop = fire && cmd_last;

    // next state
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (fire) begin
            if (cmd_last) begin
                phase_next = PH_START;
                idx_next   = IDX_ZERO;
            end else if (phase_last) begin
                phase_next = after_phase;
                idx_next   = IDX_ZERO;
            end else begin
                phase_next = cur_phase;
                idx_next   = idx_reg + IDX_W'(1);
            end
        end
    end

    // outputs and data path
    always_comb begin
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        if (fire) begin
            if (is_end_step) begin
                held_valid_next = 1'b0;
            end else begin
                held_next       = emit_char;
                held_valid_next = 1'b1;
            end
        end
        if (fire && push) begin
            out_valid_next = 1'b1;
            out_char_next  = held_reg;
            out_last_next  = cmd_last;
            out_end_next   = is_end_step;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            idx_reg        <= IDX_ZERO;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg     <= held_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

    `URNENC_ASSERT_IMP(a_end_is_last, aclk, aresetn, out_valid_reg && out_end_reg, out_last_reg)
    `URNENC_ASSERT_IMP(a_end_has_held, aclk, aresetn, cmd_valid && is_end_step, held_valid_reg)
    `URNENC_ASSERT_IMP(a_idx_range, aclk, aresetn, 1'b1, idx_reg <= IDX_PREFIX_LAST)
    `URNENC_ASSERT_NXT(a_end_drains, aclk, aresetn, fire && is_end_step, !held_valid_reg)

endmodule

`default_nettype wire

[rtl/public_id_urn_encoder_unit.sv]
// Top level of the public identifier to URN encoder.
`timescale 1ns / 1ps
`default_nettype none

// Public identifier to URN encoder. Each input beat carries one character (s_tuser
// set) and/or closes the identifier (s_tlast set). The output is the URN one
// character per beat: "urn:publicid:" once per identifier, whitespace runs trimmed
// at the ends and folded to '+' inside, % ; ' ? # + escaped, "::" to ';', "//" to
// ':', lone ':' and '/' escaped. Output is held back by one character so that the
// final character of the URN carries m_tuser; m_tlast marks the last beat caused by
// an input beat, and a beat may cause none. The front end takes one input beat per
// cycle while its four-entry command queue has room; the back end then sends one
// output character per cycle while m_tready allows, and an input beat yields one
// character for a plain character, three for an escape and thirteen more for the
// prefix at the start of an identifier.
module public_id_urn_encoder_unit (
    input  wire  logic       aclk,
    input  wire  logic       aresetn,
    input  wire  logic       s_tvalid,
    output       logic       s_tready,
    input  wire  logic [7:0] s_tdata,  // [7:0] char_in
    input  wire  logic       s_tuser,  // has_char
    input  wire  logic       s_tlast,  // end_of_id
    output       logic       m_tvalid,
    input  wire  logic       m_tready,
    output       logic [7:0] m_tdata,  // [7:0] char_out
    output       logic       m_tuser,  // end_of_urn
    output       logic       m_tlast   // last_of_run
);
    import urnenc_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic front_push;
    logic queue_not_full;
    logic queue_not_empty;
    logic back_pop;

    urnenc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_ready (queue_not_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    urnenc_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .wr_cmd    (front_cmd),
        .not_full  (queue_not_full),
        .pop       (back_pop),
        .not_empty (queue_not_empty),
        .rd_cmd    (queue_cmd)
    );

    urnenc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (back_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[verif/public_id_urn_encoder_unit_tb.sv]
// Self-checking testbench for the public identifier to URN encoder.
`timescale 1ns / 1ps

module public_id_urn_encoder_unit_tb;
    import urnenc_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       fin;
    } id_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       last;
    } urn_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    public_id_urn_encoder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    id_item_t  id_items[$];
    urn_beat_t urn_expect[$];

    logic [7:0] esc_set [6] = '{CH_PCT, CH_SEMI, CH_APOS, CH_QUEST, CH_HASH, CH_PLUS};

    // encoder state as the predictor sees it
    bit         prefix_done = 1'b0;
    bit         body_seen = 1'b0;
    bit         plus_owed = 1'b0;
    pair_t      pair_owed = PAIR_NONE;
    logic [7:0] held_ch = 8'h00;
    bit         held_ok = 1'b0;

    bit in_taken = 1'b0;
    bit calm = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_hold = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int errors = 0;
    int items_queued = 0;
    int items_taken = 0;
    int beats_seen = 0;
    int ids_closed = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Timeout: %0d beats still expected", urn_expect.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // ---------------- predictor ----------------

    // one character is always held back so the final one can carry the end mark
    function automatic void put_char(logic [7:0] c);
        if (held_ok) begin
            urn_expect.push_back('{ch: held_ch, fin: 1'b0, last: 1'b0});
        end
        held_ch = c;
        held_ok = 1'b1;
    endfunction

    function automatic logic [7:0] hex_of(logic [3:0] n);
        return (n > 4'd9) ? 8'h41 + 8'(n - 4'd10) : 8'h30 + 8'(n);
    endfunction

    function automatic void put_esc(logic [7:0] c);
        put_char(CH_PCT);
        put_char(hex_of(c[7:4]));
        put_char(hex_of(c[3:0]));
    endfunction

    function automatic void flush_owed();
        if (pair_owed == PAIR_COLON) begin
            put_esc(CH_COLON);
        end else if (pair_owed == PAIR_SLASH) begin
            put_esc(CH_SLASH);
        end
        pair_owed = PAIR_NONE;
    endfunction

    function automatic bit needs_esc(logic [7:0] c);
        bit hit;
        hit = 1'b0;
        foreach (esc_set[i]) begin
            if (esc_set[i] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void encode_char(logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            // a colon or slash pair cannot span whitespace
            if (body_seen) begin
                flush_owed();
                plus_owed = 1'b1;
            end
        end else begin
            if (plus_owed) begin
                put_char(CH_PLUS);
                plus_owed = 1'b0;
            end
            body_seen = 1'b1;
            if (c == CH_COLON) begin
                if (pair_owed == PAIR_COLON) begin
                    put_char(CH_SEMI);
                    pair_owed = PAIR_NONE;
                end else begin
                    flush_owed();
                    pair_owed = PAIR_COLON;
                end
            end else if (c == CH_SLASH) begin
                if (pair_owed == PAIR_SLASH) begin
                    put_char(CH_COLON);
                    pair_owed = PAIR_NONE;
                end else begin
                    flush_owed();
                    pair_owed = PAIR_SLASH;
                end
            end else begin
                flush_owed();
                if (needs_esc(c)) begin
                    put_esc(c);
                end else begin
                    put_char(c);
                end
            end
        end
    endfunction

    function automatic void predict_urn(id_item_t it);
        string     head;
        int        base;
        urn_beat_t tail;
        head = "urn:publicid:";
        base = urn_expect.size();
        if (it.has || it.fin) begin
            if (!prefix_done) begin
                for (int i = 0; i < head.len(); i++) put_char(head[i]);
                prefix_done = 1'b1;
            end
            if (it.has) encode_char(it.ch);
            if (it.fin) begin
                flush_owed();
                if (held_ok) begin
                    urn_expect.push_back('{ch: held_ch, fin: 1'b1, last: 1'b0});
                end
                prefix_done = 1'b0;
                body_seen   = 1'b0;
                plus_owed   = 1'b0;
                held_ok     = 1'b0;
                ids_closed++;
            end
        end
        if (urn_expect.size() > base) begin
            tail = urn_expect.pop_back();
            tail.last = 1'b1;
            urn_expect.push_back(tail);
        end
    endfunction

    // ---------------- driver and receiver ----------------

    always @(negedge aclk) begin
        id_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // beat still on offer
        end else if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            tx_gap   <= tx_gap - 1;
        end else if (id_items.size() > 0) begin
            it = id_items.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= it.ch;
            s_tuser  <= it.has;
            s_tlast  <= it.fin;
            tx_gap   <= pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            m_tready  <= 1'b0;
            rx_hold   <= 400;
            hold_done <= hold_reqs;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            rx_gap   <= pick_gap();
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        urn_beat_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_urn('{ch: s_tdata, has: s_tuser, fin: s_tlast});
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (urn_expect.size() == 0) begin
                    $error("unexpected beat: char_out %h end_of_urn %b last_of_run %b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = urn_expect.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("char_out: expected %h, got %h", want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.fin) begin
                        $error("end_of_urn: expected %b, got %b", want.fin, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void push_item(logic [7:0] c, logic has, logic fin);
        id_items.push_back('{ch: c, has: has, fin: fin});
        if (has || fin) items_queued++;
    endfunction

    function automatic void push_text(string s, bit fin_on_last);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], 1'b1, fin_on_last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] pick_char(bit esc_heavy);
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (esc_heavy && r < 50) return esc_set[$urandom_range(0, 5)];
        if (r < 35) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 50) begin
            t = $urandom_range(0, 5);
            return (t == 5) ? CH_SPACE : CH_TAB + 8'(t);
        end
        if (r < 62) return CH_COLON;
        if (r < 72) return CH_SLASH;
        if (r < 87) return esc_set[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one identifier with random content; the closing beat may or may not carry a char
    function automatic void push_random_id(int max_len, bit esc_heavy);
        int n;
        bit fin_with_char;
        n = $urandom_range(0, max_len);
        fin_with_char = $urandom_range(0, 1);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(pick_char(esc_heavy), 1'b1, fin_with_char && (k == n - 1));
        end
        if (!fin_with_char || n == 0) push_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    task automatic wait_drained();
        while (id_items.size() > 0 || s_tvalid || urn_expect.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty identifier, then pair folding and whitespace trimming
        push_item(8'h00, 1'b0, 1'b1);
        push_text(" \tA::B: /C//D/ \n", 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        // every escape, the other whitespace codes, byte extremes, an idle beat,
        // and a colon left pending at the end
        push_text("%;", 1'b0);
        push_item(8'h0B, 1'b1, 1'b0);
        push_text("'", 1'b0);
        push_item(8'h0C, 1'b1, 1'b0);
        push_text("?", 1'b0);
        push_item(CH_CR, 1'b1, 1'b0);
        push_text("#", 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_text("+:", 1'b1);
        wait_drained();

        // receiver stalls for a long stretch while escape-heavy beats keep coming
        hold_reqs++;
        while (items_queued < 65) push_random_id(10, 1'b1);
        wait_drained();

        calm = 1'b1;
        while (items_queued < 105) push_random_id(12, 1'b0);
        wait_drained();
        calm = 1'b0;

        while (items_queued < 172) push_random_id(12, 1'b0);
        wait_drained();
        repeat (40) @(posedge aclk);

        if (urn_expect.size() > 0) begin
            $error("%0d expected beats never arrived", urn_expect.size());
            errors++;
        end
        $display("Sent %0d input beats over %0d identifiers; checked %0d URN beats.",
                 items_taken, ids_closed, beats_seen);
        $display("Covered escapes, pair folding, whitespace trimming and a long output stall.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
